// ===== design/dgch_pkg.sv =====
// Package for the detection grid class histogram unit.
// Holds field widths, parameter defaults, opcode/status/register codes and stream layout.
// No dependencies.
`default_nettype none

package dgch_pkg;

  // Parameter defaults
  localparam int DEF_MAP_HEIGHT_PX = 4800;
  localparam int DEF_MAP_WIDTH_PX  = 4800;
  localparam int DEF_GRID_ROWS_MAX = 64;
  localparam int DEF_GRID_COLS_MAX = 64;
  localparam int DEF_CLASS_COUNT   = 60;
  localparam int DEF_COUNT_BITS    = 16;

  // Field widths
  localparam int COORD_BITS  = 13;
  localparam int CLASS_BITS  = 6;
  localparam int CELL_BITS   = 6;
  localparam int COUNT_OUT_W = 16;
  localparam int CFG_BITS    = 13;
  localparam int CFG_IDX_W   = 1;

  // Register reset values
  localparam logic [CFG_BITS-1:0] CELL_SIZE_RST = CFG_BITS'(75);

  // Stream layout
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  // Input tdata offsets
  localparam int FCA_LSB = 0;
  localparam int SCA_LSB = FCA_LSB + COORD_BITS;
  localparam int FCB_LSB = SCA_LSB + COORD_BITS;
  localparam int SCB_LSB = FCB_LSB + COORD_BITS;
  localparam int CLS_LSB = SCB_LSB + COORD_BITS;
  localparam int RRW_LSB = CLS_LSB + CLASS_BITS;
  localparam int RCL_LSB = RRW_LSB + CELL_BITS;
  localparam int IN_USED = RCL_LSB + CELL_BITS;

  // Output tdata offsets
  localparam int ROW_LSB  = 0;
  localparam int COL_LSB  = ROW_LSB + CELL_BITS;
  localparam int CNT_LSB  = COL_LSB + CELL_BITS;
  localparam int OUT_USED = CNT_LSB + COUNT_OUT_W;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } dgch_op_e;

  typedef enum logic {
    STAT_OK        = 1'b0,
    STAT_BAD_CLASS = 1'b1
  } dgch_status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 1'b1;

endpackage

`default_nettype wire

// ===== design/dgch_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dgch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/dgch_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on dgch_pkg.
`default_nettype none

module dgch_div
  import dgch_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [COORD_BITS-1:0] dividend_i,
  input  wire logic [COORD_BITS-1:0] divisor_i,   // never zero
  output logic                       done_o,      // one-cycle pulse
  output logic      [COORD_BITS-1:0] quotient_o   // holds until next start
);

  localparam int CNT_W = $clog2(COORD_BITS);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] quo_q, quo_d;
  logic [COORD_BITS-1:0] dvs_q, dvs_d;
  logic [COORD_BITS:0]   rem_sh;
  logic [COORD_BITS:0]   diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, quo_q[COORD_BITS-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit is dropped safely
      if (!diff[COORD_BITS]) begin
        rem_d = diff[COORD_BITS-1:0];
        quo_d = {quo_q[COORD_BITS-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[COORD_BITS-1:0];
        quo_d = {quo_q[COORD_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(COORD_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== design/detection_grid_class_histogram_unit.sv =====
// Top level of the detection grid class histogram unit.
// Depends on dgch_pkg, dgch_div and dgch_ram.
`default_nettype none

// Counts detection boxes per map cell and per object class. An accumulate
// item (tuser = 0) carries two opposite box corners and a class; the box
// centre on each axis is the floored half of the corner sum, clamped to the
// last map pixel, and is divided by cell_height (row) or cell_width (column),
// with a zero size acting as one. Row and column clamp to the last grid
// row/column. The counter for (row, column, class) is incremented, saturating
// at all ones, and the new value is returned. A read item (tuser = 1) returns
// the addressed counter unchanged. A class at or above CLASS_COUNT returns
// status 1, count 0 and touches nothing. Exactly one result item per input
// item. The block handles one item at a time: an accumulate passes from accept
// through the divide phase (divider load, 13 restoring steps and the done
// flag, row and column running side by side), then a clamp step, the line
// and address multiply steps, a RAM read and a write-back step; a read item
// skips the dividers. The next item can be accepted in the same cycle as the
// result appears. A stalled output holds the write-back step until the output
// register frees up. A new item is accepted while a finished result still
// waits in the output register. The counters live in one RAM with a write
// port and a registered read port of GRID_ROWS_MAX * GRID_COLS_MAX *
// CLASS_COUNT words (245760 at defaults); after reset a clearing pass writes
// zeros one word per cycle, so no item is accepted until every word is
// cleared. Configuration writes are taken at any time but must only be
// issued while the block is idle.

module detection_grid_class_histogram_unit
  import dgch_pkg::*;
#(
  parameter int MAP_HEIGHT_PX = DEF_MAP_HEIGHT_PX,
  parameter int MAP_WIDTH_PX  = DEF_MAP_WIDTH_PX,
  parameter int GRID_ROWS_MAX = DEF_GRID_ROWS_MAX,
  parameter int GRID_COLS_MAX = DEF_GRID_COLS_MAX,
  parameter int CLASS_COUNT   = DEF_CLASS_COUNT,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_BITS-1:0]    cfg_wdata_i,
  // input stream
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [12:0] first_coord_a, [25:13] second_coord_a, [38:26] first_coord_b,
  // [51:39] second_coord_b, [57:52] object_class, [63:58] read_row,
  // [69:64] read_col, [71:70] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                   s_axis_tuser_i,  // [0] opcode
  // result stream
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [5:0] cell_row, [11:6] cell_col, [27:12] count_value, [31:28] zero
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                        m_axis_tuser_o   // [0] status
);

  localparam int DEPTH    = GRID_ROWS_MAX * GRID_COLS_MAX * CLASS_COUNT;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RC_N     = GRID_ROWS_MAX * GRID_COLS_MAX;
  localparam int RCW      = (RC_N > 1) ? $clog2(RC_N) : 1;
  localparam int RW       = (GRID_ROWS_MAX > 1) ? $clog2(GRID_ROWS_MAX) : 1;
  localparam int CW       = (GRID_COLS_MAX > 1) ? $clog2(GRID_COLS_MAX) : 1;
  localparam int H_LAST   = MAP_HEIGHT_PX - 1;
  localparam int W_LAST   = MAP_WIDTH_PX - 1;
  localparam int ROW_LAST = GRID_ROWS_MAX - 1;
  localparam int COL_LAST = GRID_COLS_MAX - 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR,  // zero the counter RAM after reset
    S_IDLE,
    S_DIV,    // wait for the axis dividers
    S_CELL,   // clamp row and column
    S_LINE,   // row * cols + col
    S_ADDR,   // (row * cols + col) * classes + class
    S_READ,   // issue counter read
    S_UPD     // increment, write back, post result
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_BITS-1:0] cell_h_q, cell_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_h_q <= CELL_SIZE_RST;
      cell_w_q <= CELL_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CELL_HEIGHT: cell_h_q <= cfg_wdata_i;
        CFG_CELL_WIDTH:  cell_w_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode: box centres, clamped to the map
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] fca, sca, fcb, scb;
  logic [CLASS_BITS-1:0] in_cls;
  logic [CELL_BITS-1:0]  in_rrow, in_rcol;
  logic [COORD_BITS:0]   sum_h, sum_w;
  logic [COORD_BITS-1:0] cen_h, cen_w, cen_h_sat, cen_w_sat;
  logic [COORD_BITS-1:0] dvs_h, dvs_w;
  logic                  in_acc;
  dgch_op_e              in_op;

  assign fca     = s_axis_tdata_i[FCA_LSB +: COORD_BITS];
  assign sca     = s_axis_tdata_i[SCA_LSB +: COORD_BITS];
  assign fcb     = s_axis_tdata_i[FCB_LSB +: COORD_BITS];
  assign scb     = s_axis_tdata_i[SCB_LSB +: COORD_BITS];
  assign in_cls  = s_axis_tdata_i[CLS_LSB +: CLASS_BITS];
  assign in_rrow = s_axis_tdata_i[RRW_LSB +: CELL_BITS];
  assign in_rcol = s_axis_tdata_i[RCL_LSB +: CELL_BITS];
  assign in_op   = dgch_op_e'(s_axis_tuser_i);

  assign sum_h = {1'b0, fca} + {1'b0, fcb};
  assign sum_w = {1'b0, sca} + {1'b0, scb};
  assign cen_h = sum_h[COORD_BITS:1];
  assign cen_w = sum_w[COORD_BITS:1];
  assign cen_h_sat = (32'(cen_h) > H_LAST) ? COORD_BITS'(H_LAST) : cen_h;
  assign cen_w_sat = (32'(cen_w) > W_LAST) ? COORD_BITS'(W_LAST) : cen_w;

  // zero cell size divides as one
  assign dvs_h = (cell_h_q == '0) ? COORD_BITS'(1) : COORD_BITS'(cell_h_q);
  assign dvs_w = (cell_w_q == '0) ? COORD_BITS'(1) : COORD_BITS'(cell_w_q);

  logic in_fire;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign in_acc  = in_fire && (in_op == OP_ACCUM);

  // ---------------------------------------------------------------------------
  // Axis dividers
  // ---------------------------------------------------------------------------
  logic                  row_done, col_done;
  logic [COORD_BITS-1:0] row_quo, col_quo;

  dgch_div u_div_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (cen_h_sat),
    .divisor_i  (dvs_h),
    .done_o     (row_done),
    .quotient_o (row_quo)
  );

  dgch_div u_div_col (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .dividend_i (cen_w_sat),
    .divisor_i  (dvs_w),
    .done_o     (col_done),
    .quotient_o (col_quo)
  );

  // ---------------------------------------------------------------------------
  // Counter RAM
  // ---------------------------------------------------------------------------
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  // item registers
  dgch_op_e              op_q, op_d;
  logic [CLASS_BITS-1:0] cls_q, cls_d;
  logic [CELL_BITS-1:0]  rrow_q, rrow_d, rcol_q, rcol_d;
  logic [RW-1:0]         row_q, row_d;
  logic [CW-1:0]         col_q, col_d;
  logic                  cls_ok_q, cls_ok_d;
  logic [RCW-1:0]        line_q, line_d;
  logic [AW-1:0]         addr_q, addr_d;

  dgch_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;
  dgch_status_e           m_stat_q, m_stat_d;
  logic                   out_free;
  logic                   bump;
  logic [COUNT_BITS-1:0]  cnt_new;
  logic [COUNT_BITS-1:0]  cnt_res;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign bump     = cls_ok_q && (op_q == OP_ACCUM) && (ram_rdata != CNT_MAX);
  assign cnt_new  = bump ? ram_rdata + COUNT_BITS'(1) : ram_rdata;
  assign cnt_res  = cls_ok_q ? cnt_new : '0;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_stat_d  = m_stat_q;
    op_d      = op_q;
    cls_d     = cls_q;
    rrow_d    = rrow_q;
    rcol_d    = rcol_q;
    row_d     = row_q;
    col_d     = col_q;
    cls_ok_d  = cls_ok_q;
    line_d    = line_q;
    addr_d    = addr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = cnt_new;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_d    = in_op;
          cls_d   = in_cls;
          rrow_d  = in_rrow;
          rcol_d  = in_rcol;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (op_q == OP_READ || row_done) begin
          state_d = S_CELL;
        end
      end
      S_CELL: begin
        if (op_q == OP_ACCUM) begin
          row_d = (32'(row_quo) > ROW_LAST) ? RW'(ROW_LAST) : RW'(row_quo);
          col_d = (32'(col_quo) > COL_LAST) ? CW'(COL_LAST) : CW'(col_quo);
        end else begin
          row_d = (32'(rrow_q) > ROW_LAST) ? RW'(ROW_LAST) : RW'(rrow_q);
          col_d = (32'(rcol_q) > COL_LAST) ? CW'(COL_LAST) : CW'(rcol_q);
        end
        cls_ok_d = 32'(cls_q) < CLASS_COUNT;
        state_d  = S_LINE;
      end
      S_LINE: begin
        line_d  = RCW'(32'(row_q) * 32'(GRID_COLS_MAX) + 32'(col_q));
        state_d = S_ADDR;
      end
      S_ADDR: begin
        addr_d  = AW'(32'(line_q) * 32'(CLASS_COUNT) + 32'(cls_q));
        state_d = S_READ;
      end
      S_READ: begin
        // an invalid class may point past the store: skip the read
        ram_re  = cls_ok_q;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          ram_we    = bump;
          m_valid_d = 1'b1;
          m_stat_d  = cls_ok_q ? STAT_OK : STAT_BAD_CLASS;
          m_data_d  = '0;
          m_data_d[ROW_LSB +: CELL_BITS]   = CELL_BITS'(row_q);
          m_data_d[COL_LSB +: CELL_BITS]   = CELL_BITS'(col_q);
          m_data_d[CNT_LSB +: COUNT_OUT_W] = COUNT_OUT_W'(cnt_res);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_stat_q  <= STAT_OK;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_stat_q  <= m_stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    cls_q    <= cls_d;
    rrow_q   <= rrow_d;
    rcol_q   <= rcol_d;
    row_q    <= row_d;
    col_q    <= col_d;
    cls_ok_q <= cls_ok_d;
    line_q   <= line_d;
    addr_q   <= addr_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_stat_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  // both axis dividers start together and must finish together
  assert property (@(posedge clk_i) disable iff (!rst_ni) row_done == col_done)
    else $error("axis dividers out of step");

  // an accepted item always enters the divide phase next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == S_DIV))
    else $error("accepted item not started");

  // a new result only comes out of the write-back step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_UPD))
    else $error("result posted outside write-back");

  // a rejected class never reports a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == STAT_BAD_CLASS)
      |-> (m_axis_tdata_o[CNT_LSB +: COUNT_OUT_W] == '0))
    else $error("bad class with nonzero count");
`endif

endmodule

`default_nettype wire
